// ===== hw/rtl/khvi_pkg.sv =====
// Shared types and constants for the keyframe Hermite vector interpolator.
// No dependencies; imported by khvi_ctrl, khvi_datapath and the top level.
package khvi_pkg;

   localparam int MAX_KEYS = 256;
   localparam int ADDR_W   = $clog2(MAX_KEYS);
   localparam int COUNT_W  = 9;
   localparam int KEY_W    = 32;
   localparam int FRAC_W   = 17;
   localparam int DIFF_W   = KEY_W + 1;
   localparam int OPA_W    = 36;   // multiplier operand: keys x4 and Q18 tangents
   localparam int OPB_W    = 28;   // multiplier operand: Q24 weights or fraction
   localparam int PROD_W   = OPA_W + OPB_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int WSUM_W   = 53;   // exact Q48 basis sums
   localparam int STEP_W   = 3;

   localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
   localparam logic [STEP_W-1:0] FETCH_LAST  = STEP_W'(3);
   localparam logic [STEP_W-1:0] SPLINE_LAST = STEP_W'(7);
   localparam logic [STEP_W-1:0] LINEAR_LAST = STEP_W'(0);

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_EVAL  = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PREP,
      ST_MAC,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              write;
      logic              load;
      logic              fetch;
      logic              prep;
      logic              mul_en;
      logic [STEP_W-1:0] step;
      logic              out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic spline;
      logic few;
   } dp_status_type;

endpackage

// ===== hw/rtl/khvi_ctrl.sv =====
// Sequencer for the interpolator: accepts requests, steps fetch, prep, MAC and output.
// Depends on khvi_pkg; drives khvi_datapath through ctrl_cmd_type.
module khvi_ctrl import khvi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_command,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid && req_command == CMD_EVAL) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            if (cnt_ff == FETCH_LAST) begin
               state_in = ST_PREP;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_PREP: begin
            cnt_in   = '0;
            state_in = status.few ? ST_DONE : ST_MAC;
         end
         ST_MAC: begin
            if (cnt_ff == (status.spline ? SPLINE_LAST : LINEAR_LAST)) begin
               state_in = ST_DRAIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd.write    = (state_ff == ST_IDLE) && req_valid && req_command == CMD_WRITE;
      cmd.load     = (state_ff == ST_IDLE) && req_valid && req_command == CMD_EVAL;
      cmd.fetch    = (state_ff == ST_FETCH);
      cmd.prep     = (state_ff == ST_PREP);
      cmd.mul_en   = (state_ff == ST_MAC);
      cmd.step     = cnt_ff;
      cmd.out_load = (state_ff == ST_DONE) && out_free;
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten while still pending");
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (!req_ready && state_ff == ST_FETCH))
      else $error("evaluate request did not start the fetch");
   a_fetch_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> !cnt_ff[2])
      else $error("fetch counter out of range");
   a_mul_linear: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul_en && !status.spline) |-> (cnt_ff == LINEAR_LAST))
      else $error("linear mode ran more than one product");
`endif

endmodule

// ===== hw/rtl/khvi_datapath.sv =====
// Key store, basis weights, tangent prep, 3-lane multiply-accumulate and output registers.
// Depends on khvi_pkg; sequenced by khvi_ctrl.
module khvi_datapath import khvi_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [COUNT_W-1:0]       csr_write_data,
   input  logic [ADDR_W-1:0]        key_index,
   input  logic signed [KEY_W-1:0]  key_x,
   input  logic signed [KEY_W-1:0]  key_y,
   input  logic signed [KEY_W-1:0]  key_z,
   input  logic [ADDR_W-1:0]        segment_index,
   input  logic [FRAC_W-1:0]        fraction,
   input  logic                     use_spline,
   input  ctrl_cmd_type             cmd,
   output dp_status_type            status,
   output logic signed [KEY_W-1:0]  pos_x,
   output logic signed [KEY_W-1:0]  pos_y,
   output logic signed [KEY_W-1:0]  pos_z,
   output logic signed [KEY_W-1:0]  tan_x,
   output logic signed [KEY_W-1:0]  tan_y,
   output logic signed [KEY_W-1:0]  tan_z
);

   localparam logic signed [WSUM_W-1:0] Q48_ONE  = WSUM_W'(1) << 48;
   localparam logic signed [WSUM_W-1:0] W_ROUND  = WSUM_W'(1) << 23;
   localparam logic signed [ACC_W-1:0]  SAT_HI   = ACC_W'(64'sh7FFFFFFF);
   localparam logic signed [ACC_W-1:0]  SAT_LO   = -(ACC_W'(64'sh80000000));
   localparam logic signed [ACC_W-1:0]  TAN_UNIT = ACC_W'(1) << 32;

   function automatic logic signed [KEY_W-1:0] round_sat(input logic signed [ACC_W-1:0] v,
                                                         input logic wide);
      logic signed [ACC_W-1:0] r;
      r = wide ? ((v + (ACC_W'(1) << 25)) >>> 26) : ((v + (ACC_W'(1) << 15)) >>> 16);
      if (r > SAT_HI) return SAT_HI[KEY_W-1:0];
      if (r < SAT_LO) return SAT_LO[KEY_W-1:0];
      return r[KEY_W-1:0];
   endfunction

   // store, one write and one read port, read data registered in the window
   logic [3*KEY_W-1:0] key_mem [MAX_KEYS];
   logic [3*KEY_W-1:0] win_ff [4];

   logic [COUNT_W-1:0]      key_count_ff;
   logic [ADDR_W-1:0]       seg_ff;
   logic [FRAC_W-1:0]       t_ff;
   logic                    spline_req_ff;
   logic [2*FRAC_W-1:0]     tt_ff;
   logic [3*FRAC_W-1:0]     ttt_ff;
   logic signed [OPB_W-1:0] w_ff [8];

   logic signed [OPA_W-1:0]  p4_ff [3], q4_ff [3], m0_ff [3], m1_ff [3], d_ff [3];
   logic signed [PROD_W-1:0] prod_ff [3];
   logic                     add_en_ff, add_der_ff;
   logic signed [ACC_W-1:0]  pos_acc_ff [3], der_acc_ff [3];
   logic signed [KEY_W-1:0]  pos_out_ff [3], tan_out_ff [3];

   logic [COUNT_W-1:0] n, n_m1, prev, base;
   logic               few, spline, first, last, pen;
   logic [ADDR_W-1:0]  rd_addr;

   always_comb begin
      n     = (key_count_ff > COUNT_W'(MAX_KEYS)) ? COUNT_W'(MAX_KEYS) : key_count_ff;
      n_m1  = n - 1'b1;
      prev  = ({1'b0, seg_ff} > n_m1) ? n_m1 : {1'b0, seg_ff};
      few   = (n < COUNT_W'(2));
      spline = spline_req_ff && (n >= COUNT_W'(3));
      first = (prev == '0);
      last  = (prev == n_m1);
      pen   = (prev == n - COUNT_W'(2));
      // window start so that every key the segment needs lands in win_ff
      if (few)         base = '0;
      else if (spline) base = first ? '0 : (last ? n - COUNT_W'(3) : prev - 1'b1);
      else             base = last ? n - COUNT_W'(2) : prev;
      rd_addr = base[ADDR_W-1:0] + ADDR_W'(cmd.step);
   end

   assign status.few    = few;
   assign status.spline = spline;

   always_ff @(posedge clock) begin
      if (cmd.write) key_mem[key_index] <= {key_z, key_y, key_x};
      if (cmd.fetch) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= win_ff[3];
         win_ff[3] <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) key_count_ff <= '0;
      else if (csr_write_enable) key_count_ff <= csr_write_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         seg_ff        <= segment_index;
         t_ff          <= (fraction > FRAC_ONE) ? FRAC_ONE : fraction;
         spline_req_ff <= use_spline;
      end
   end

   // basis weights: t^2, t^3, then the eight Q48 sums rounded to Q24
   logic signed [WSUM_W-1:0] t1, t2, t3, t2x3, s [8];

   always_comb begin
      t1   = WSUM_W'({t_ff, 32'b0});
      t2   = WSUM_W'({tt_ff, 16'b0});
      t3   = WSUM_W'(ttt_ff);
      t2x3 = (t2 <<< 1) + t2;
      s[0] = (t3 <<< 1) - t2x3 + Q48_ONE;
      s[1] = t1 - (t2 <<< 1) + t3;
      s[2] = t2x3 - (t3 <<< 1);
      s[3] = t3 - t2;
      s[4] = (t2x3 <<< 1) - ((t1 <<< 2) + (t1 <<< 1));
      s[5] = t2x3 - (t1 <<< 2) + Q48_ONE;
      s[6] = ((t1 <<< 2) + (t1 <<< 1)) - (t2x3 <<< 1);
      s[7] = t2x3 - (t1 <<< 1);
   end

   always_ff @(posedge clock) begin
      tt_ff  <= t_ff * t_ff;
      ttt_ff <= tt_ff * t_ff;
      for (int i = 0; i < 8; i++) begin
         w_ff[i] <= OPB_W'((s[i] + W_ROUND) >>> 24);
      end
   end

   // per-lane operand prep
   logic signed [KEY_W-1:0]  k0 [3], k1 [3], k2 [3], k3 [3];
   logic signed [DIFF_W-1:0] d10 [3], d20 [3], d21 [3], d31 [3];
   logic signed [OPA_W-1:0]  end_a [3], end_b [3], mid0 [3], mid1 [3];
   logic signed [OPA_W-1:0]  p_sel [3], q_sel [3], m0_sel [3], m1_sel [3], dl [3];
   logic signed [ACC_W-1:0]  pos_init [3], der_init [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         k0[c]  = win_ff[0][c*KEY_W +: KEY_W];
         k1[c]  = win_ff[1][c*KEY_W +: KEY_W];
         k2[c]  = win_ff[2][c*KEY_W +: KEY_W];
         k3[c]  = win_ff[3][c*KEY_W +: KEY_W];
         d10[c] = DIFF_W'(k1[c]) - DIFF_W'(k0[c]);
         d20[c] = DIFF_W'(k2[c]) - DIFF_W'(k0[c]);
         d21[c] = DIFF_W'(k2[c]) - DIFF_W'(k1[c]);
         d31[c] = DIFF_W'(k3[c]) - DIFF_W'(k1[c]);
         end_a[c] = (OPA_W'(d10[c]) <<< 2) + (OPA_W'(d10[c]) <<< 1) - OPA_W'(d20[c]);
         end_b[c] = (OPA_W'(d21[c]) <<< 2) + (OPA_W'(d21[c]) <<< 1) - OPA_W'(d20[c]);
         mid0[c]  = OPA_W'(d20[c]) <<< 1;
         mid1[c]  = OPA_W'(d31[c]) <<< 1;
         if (first) begin
            p_sel[c] = OPA_W'(k0[c]);  q_sel[c] = OPA_W'(k1[c]);
            m0_sel[c] = end_a[c];      m1_sel[c] = mid0[c];
         end else if (last) begin
            p_sel[c] = OPA_W'(k2[c]);  q_sel[c] = OPA_W'(k2[c]);
            m0_sel[c] = end_b[c];      m1_sel[c] = end_b[c];
         end else if (pen) begin
            p_sel[c] = OPA_W'(k1[c]);  q_sel[c] = OPA_W'(k2[c]);
            m0_sel[c] = mid0[c];       m1_sel[c] = end_b[c];
         end else begin
            p_sel[c] = OPA_W'(k1[c]);  q_sel[c] = OPA_W'(k2[c]);
            m0_sel[c] = mid0[c];       m1_sel[c] = mid1[c];
         end
         // linear: at the last key the position holds and the tangent is the last step
         dl[c] = last ? '0 : OPA_W'(d10[c]);
         if (few) begin
            pos_init[c] = (n == COUNT_W'(1)) ? (ACC_W'(k0[c]) <<< 16) : '0;
            der_init[c] = (c == 1) ? TAN_UNIT : '0;
         end else if (spline) begin
            pos_init[c] = '0;
            der_init[c] = '0;
         end else begin
            pos_init[c] = ACC_W'(last ? k1[c] : k0[c]) <<< 16;
            der_init[c] = ACC_W'(d10[c]) <<< 16;
         end
      end
   end

   // multiply-accumulate: spline steps 0-3 build position, 4-7 the derivative
   logic signed [OPA_W-1:0] mul_a [3];
   logic signed [OPB_W-1:0] mul_b;

   always_comb begin
      mul_b = spline ? w_ff[cmd.step] : signed'({{(OPB_W-FRAC_W){1'b0}}, t_ff});
      for (int c = 0; c < 3; c++) begin
         if (!spline) mul_a[c] = d_ff[c];
         else begin
            case (cmd.step[1:0])
               2'd0:    mul_a[c] = p4_ff[c];
               2'd1:    mul_a[c] = m0_ff[c];
               2'd2:    mul_a[c] = q4_ff[c];
               default: mul_a[c] = m1_ff[c];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         add_en_ff  <= 1'b0;
         add_der_ff <= 1'b0;
      end else begin
         add_en_ff  <= cmd.mul_en;
         add_der_ff <= spline && cmd.step[2];
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (cmd.prep) begin
            p4_ff[c]      <= p_sel[c] <<< 2;
            q4_ff[c]      <= q_sel[c] <<< 2;
            m0_ff[c]      <= m0_sel[c];
            m1_ff[c]      <= m1_sel[c];
            d_ff[c]       <= dl[c];
            pos_acc_ff[c] <= pos_init[c];
            der_acc_ff[c] <= der_init[c];
         end else if (add_en_ff) begin
            if (add_der_ff) der_acc_ff[c] <= der_acc_ff[c] + ACC_W'(prod_ff[c]);
            else            pos_acc_ff[c] <= pos_acc_ff[c] + ACC_W'(prod_ff[c]);
         end
         if (cmd.mul_en) prod_ff[c] <= mul_a[c] * mul_b;
         if (cmd.out_load) begin
            pos_out_ff[c] <= round_sat(pos_acc_ff[c], spline);
            tan_out_ff[c] <= round_sat(der_acc_ff[c], spline);
         end
      end
   end

   assign pos_x = pos_out_ff[0];
   assign pos_y = pos_out_ff[1];
   assign pos_z = pos_out_ff[2];
   assign tan_x = tan_out_ff[0];
   assign tan_y = tan_out_ff[1];
   assign tan_z = tan_out_ff[2];

endmodule

// ===== hw/rtl/keyframe_hermite_vector_interp_unit.sv =====
// Keyframe Hermite vector interpolator, top level. Uses khvi_pkg, khvi_ctrl, khvi_datapath.
// Write request: taken back to back, no response.
// Evaluate request: rsp_valid rises after the fetch, prep, MAC and drain states, or after
// fetch and prep alone with fewer than two keys; the next request is taken once the response
// registers, so one evaluate at a time (later while an earlier response is still pending).
// Paced by the single store read port (four reads) and one shared multiplier per lane (eight
// products). Reset clears the key count and control; the key store is undefined until written.
module keyframe_hermite_vector_interp_unit import khvi_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [COUNT_W-1:0]       csr_write_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_command,
   input  logic [7:0]               req_key_index,
   input  logic signed [KEY_W-1:0]  req_key_x,
   input  logic signed [KEY_W-1:0]  req_key_y,
   input  logic signed [KEY_W-1:0]  req_key_z,
   input  logic [7:0]               req_segment_index,
   input  logic [FRAC_W-1:0]        req_fraction,
   input  logic                     req_use_spline,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [KEY_W-1:0]  rsp_pos_x,
   output logic signed [KEY_W-1:0]  rsp_pos_y,
   output logic signed [KEY_W-1:0]  rsp_pos_z,
   output logic signed [KEY_W-1:0]  rsp_tan_x,
   output logic signed [KEY_W-1:0]  rsp_tan_y,
   output logic signed [KEY_W-1:0]  rsp_tan_z
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   khvi_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   khvi_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .key_index        (req_key_index),
      .key_x            (req_key_x),
      .key_y            (req_key_y),
      .key_z            (req_key_z),
      .segment_index    (req_segment_index),
      .fraction         (req_fraction),
      .use_spline       (req_use_spline),
      .cmd              (cmd),
      .status           (status),
      .pos_x            (rsp_pos_x),
      .pos_y            (rsp_pos_y),
      .pos_z            (rsp_pos_z),
      .tan_x            (rsp_tan_x),
      .tan_y            (rsp_tan_y),
      .tan_z            (rsp_tan_z)
   );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for keyframe_hermite_vector_interp_unit: directed table, then
// random key writes and evaluations checked against an in-bench Hermite/linear predictor.
// Depends on khvi_pkg and the RTL top level only.
module tb_top;
   import khvi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;

   typedef struct {
      logic signed [31:0] pos[3];
      logic signed [31:0] tang[3];
   } interp_type;

   typedef struct {
      row_kind_type       kind;
      command_type        cmd;
      logic [7:0]         idx;
      logic signed [31:0] key[3];
      logic [7:0]         seg;
      logic [16:0]        frac;
      logic               spline;
      int                 count;
      bit                 typed;
      interp_type         want;
   } request_type;

   localparam logic signed [31:0] KMAX = 32'sh7fffffff;
   localparam logic signed [31:0] KMIN = 32'sh80000000;
   localparam logic signed [31:0] ONE  = 32'sd65536;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [COUNT_W-1:0] csr_write_data;
   logic req_valid, req_ready;
   logic req_command;
   logic [7:0] req_key_index, req_segment_index;
   logic signed [KEY_W-1:0] req_key_x, req_key_y, req_key_z;
   logic [FRAC_W-1:0] req_fraction;
   logic req_use_spline;
   logic rsp_valid, rsp_ready;
   logic signed [KEY_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [KEY_W-1:0] rsp_tan_x, rsp_tan_y, rsp_tan_z;

   keyframe_hermite_vector_interp_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   longint     key_mem[MAX_KEYS][3];
   int         key_count;
   interp_type expected_interp[$];
   int         errors;
   int         send_idle_pct;
   int         rsp_stall_pct;
   int         accepted;
   request_type directed[$];

   function automatic longint round_q(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic logic signed [31:0] clip32(longint v);
      if (v > longint'(KMAX)) return KMAX;
      if (v < longint'(KMIN)) return KMIN;
      return v[31:0];
   endfunction

   // Catmull-Rom tangent in Q18, one-sided at the ends
   function automatic longint knot_slope(int n, int i, int c);
      if (i == 0)
         return 6 * (key_mem[1][c] - key_mem[0][c]) - (key_mem[2][c] - key_mem[0][c]);
      if (i >= n - 1)
         return 6 * (key_mem[n-1][c] - key_mem[n-2][c]) - (key_mem[n-1][c] - key_mem[n-3][c]);
      return 2 * (key_mem[i+1][c] - key_mem[i-1][c]);
   endfunction

   function automatic interp_type interpolate(int seg, int frac, bit spline);
      interp_type r;
      int n, prev, nxt, lo;
      longint t, one, t1, t2, t3, h00, h10, h01, h11, da, db, dc, dd, p, q, m0, m1, d;
      n = key_count > MAX_KEYS ? MAX_KEYS : key_count;
      if (n < 2) begin
         for (int c = 0; c < 3; c++) r.pos[c] = n != 0 ? clip32(key_mem[0][c]) : '0;
         r.tang[0] = '0;
         r.tang[1] = ONE;
         r.tang[2] = '0;
         return r;
      end
      prev = seg > n - 1 ? n - 1 : seg;
      nxt = prev + 1 > n - 1 ? n - 1 : prev + 1;
      t = frac > 65536 ? 65536 : frac;
      if (spline && n >= 3) begin
         one = longint'(1) << 48;
         t1 = t << 32;
         t2 = (t * t) << 16;
         t3 = t * t * t;
         h00 = round_q(2 * t3 - 3 * t2 + one, 24);
         h10 = round_q(t1 - 2 * t2 + t3, 24);
         h01 = round_q(3 * t2 - 2 * t3, 24);
         h11 = round_q(t3 - t2, 24);
         da = round_q(6 * t2 - 6 * t1, 24);
         db = round_q(3 * t2 - 4 * t1 + one, 24);
         dc = round_q(6 * t1 - 6 * t2, 24);
         dd = round_q(3 * t2 - 2 * t1, 24);
         for (int c = 0; c < 3; c++) begin
            p = 4 * key_mem[prev][c];
            q = 4 * key_mem[nxt][c];
            m0 = knot_slope(n, prev, c);
            m1 = knot_slope(n, prev + 1, c);
            r.pos[c] = clip32(round_q(p * h00 + m0 * h10 + q * h01 + m1 * h11, 26));
            r.tang[c] = clip32(round_q(p * da + m0 * db + q * dc + m1 * dd, 26));
         end
      end else begin
         lo = prev == n - 1 ? prev - 1 : prev;
         for (int c = 0; c < 3; c++) begin
            p = key_mem[prev][c];
            d = key_mem[nxt][c] - p;
            r.pos[c] = clip32(round_q((p << 16) + d * t, 16));
            r.tang[c] = clip32(key_mem[lo+1][c] - key_mem[lo][c]);
         end
      end
      return r;
   endfunction

   task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
      $display("tb_top: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic request_type key_write(int idx, logic signed [31:0] x,
                                             logic signed [31:0] y, logic signed [31:0] z);
      request_type r;
      r = '{kind: ROW_REQ, cmd: CMD_WRITE, default: '0};
      r.idx = 8'(idx);
      r.key[0] = x;
      r.key[1] = y;
      r.key[2] = z;
      return r;
   endfunction

   function automatic request_type key_eval(int seg, int frac, bit spline);
      request_type r;
      r = '{kind: ROW_REQ, cmd: CMD_EVAL, default: '0};
      r.seg = 8'(seg);
      r.frac = 17'(frac);
      r.spline = spline;
      r.idx = 8'($urandom);
      for (int c = 0; c < 3; c++) r.key[c] = $urandom;
      return r;
   endfunction

   function automatic request_type count_write(int v);
      request_type r;
      r = '{kind: ROW_CFG, cmd: CMD_WRITE, default: '0};
      r.count = v;
      return r;
   endfunction

   function automatic request_type typed_eval(int seg, int frac, bit spline,
                                              logic signed [31:0] px, logic signed [31:0] py,
                                              logic signed [31:0] pz, logic signed [31:0] tx,
                                              logic signed [31:0] ty, logic signed [31:0] tz);
      request_type r;
      r = key_eval(seg, frac, spline);
      r.typed = 1'b1;
      r.want.pos = '{px, py, pz};
      r.want.tang = '{tx, ty, tz};
      return r;
   endfunction

   function automatic logic signed [31:0] random_key();
      case ($urandom_range(7))
         0: return KMAX;
         1: return KMIN;
         2: return '0;
         3: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         default: return $urandom;
      endcase
   endfunction

   function automatic int random_fraction();
      case ($urandom_range(5))
         0: return 0;
         1: return 65536;
         2: return $urandom_range(65537, 17'h1ffff);
         default: return $urandom_range(0, 65536);
      endcase
   endfunction

   // block must be idle: drain responses, then let any write in flight settle
   task automatic set_count(int v);
      req_valid <= 1'b0;
      while (expected_interp.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= COUNT_W'(v);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      key_count = v & 9'h1ff;
   endtask

   task automatic send(request_type r);
      bit fire;
      int gap;
      if (r.kind == ROW_CFG) begin
         set_count(r.count);
         return;
      end
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= r.cmd;
      req_key_index <= r.idx;
      req_key_x <= r.key[0];
      req_key_y <= r.key[1];
      req_key_z <= r.key[2];
      req_segment_index <= r.seg;
      req_fraction <= r.frac;
      req_use_spline <= r.spline;
      do begin
         @(negedge clock);
         fire = req_valid && req_ready;
         @(posedge clock);
      end while (!fire);
      accepted++;
      if (r.cmd == CMD_WRITE) begin
         for (int c = 0; c < 3; c++) key_mem[r.idx][c] = r.key[c];
      end else if (r.typed) begin
         expected_interp.push_back(r.want);
      end else begin
         expected_interp.push_back(interpolate(r.seg, r.frac, r.spline));
      end
   endtask

   always @(posedge clock)
      rsp_ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);

   // handshake signals are stable between the falling and the next rising edge
   always @(negedge clock) begin
      interp_type w;
      interp_type g;
      if (!reset && rsp_valid && rsp_ready) begin
         g.pos = '{rsp_pos_x, rsp_pos_y, rsp_pos_z};
         g.tang = '{rsp_tan_x, rsp_tan_y, rsp_tan_z};
         if (expected_interp.size() == 0) begin
            $display("tb_top: response with none pending at %0t", $realtime);
            errors++;
         end else begin
            w = expected_interp.pop_front();
            for (int c = 0; c < 3; c++) begin
               if (g.pos[c] !== w.pos[c]) report($sformatf("pos[%0d]", c), g.pos[c], w.pos[c]);
               if (g.tang[c] !== w.tang[c])
                  report($sformatf("tan[%0d]", c), g.tang[c], w.tang[c]);
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("tb_top: timeout");
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      int target, n, burst;
      request_type r;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_command = CMD_WRITE;
      req_key_index = '0;
      req_key_x = '0;
      req_key_y = '0;
      req_key_z = '0;
      req_segment_index = '0;
      req_fraction = '0;
      req_use_spline = 1'b0;
      errors = 0;
      accepted = 0;
      key_count = 0;
      send_idle_pct = 14;
      rsp_stall_pct = 56;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no keys, one key, two keys (spline forced linear), then short splines
      directed.push_back(typed_eval(0, 32768, 1'b1, 0, 0, 0, 0, ONE, 0));
      directed.push_back(key_write(0, KMAX, KMIN, ONE));
      directed.push_back(count_write(1));
      directed.push_back(typed_eval(255, 17'h1ffff, 1'b0, KMAX, KMIN, ONE, 0, ONE, 0));
      directed.push_back(key_write(1, KMIN, KMAX, -ONE));
      directed.push_back(key_write(2, 0, 32'sh00012345, 32'sh7fff0000));
      directed.push_back(key_write(3, KMAX, -32'sd7, 32'sh80010000));
      directed.push_back(count_write(2));
      directed.push_back(typed_eval(0, 0, 1'b1, KMAX, KMIN, ONE, KMIN, KMAX, -2 * ONE));
      directed.push_back(key_eval(200, 17'h1ffff, 1'b0));
      directed.push_back(key_eval(0, 32768, 1'b0));
      directed.push_back(count_write(3));
      directed.push_back(key_eval(0, 0, 1'b1));
      directed.push_back(key_eval(1, 65536, 1'b1));
      directed.push_back(key_eval(2, 12345, 1'b1));
      directed.push_back(key_eval(2, 40000, 1'b0));
      directed.push_back(count_write(4));
      directed.push_back(key_eval(0, 1, 1'b1));
      directed.push_back(key_eval(1, 32768, 1'b1));
      directed.push_back(key_eval(2, 65535, 1'b1));
      directed.push_back(key_eval(3, 65536, 1'b1));
      directed.push_back(key_eval(255, 17'h10001, 1'b1));
      directed.push_back(key_eval(3, 20000, 1'b0));
      foreach (directed[i]) send(directed[i]);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 14 : (phase == 1 ? 56 : 0);
         rsp_stall_pct = phase == 0 ? 56 : (phase == 1 ? 14 : 0);
         target = accepted + 580;
         // every entry written, so any count and segment reads defined keys
         if (phase == 0)
            for (int k = 0; k < MAX_KEYS; k++)
               send(key_write(k, random_key(), random_key(), random_key()));
         while (accepted < target) begin
            case ($urandom_range(9))
               0: n = $urandom_range(0, 2);
               1: n = 3;
               2: n = 4;
               3: n = 256;
               4: n = $urandom_range(257, 511);
               5: n = 511;
               default: n = $urandom_range(5, 256);
            endcase
            send(count_write(n));
            burst = $urandom_range(20, 60);
            for (int j = 0; j < burst; j++) begin
               if ($urandom_range(3) == 0)
                  r = key_write($urandom_range(0, 255), random_key(), random_key(), random_key());
               else if ($urandom_range(1) == 0)
                  r = key_eval($urandom_range(0, n < 256 ? n : 255), random_fraction(),
                               $urandom_range(3) != 0);
               else
                  r = key_eval($urandom_range(0, 255), random_fraction(), $urandom_range(1));
               send(r);
            end
         end
      end

      req_valid <= 1'b0;
      while (expected_interp.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (errors == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
